FILE: rtl/core/pkbis_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkbis_pkg
// Shared types and constants of the per-key bounded identifier set core.
// ----------------------------------------------------------------------------
package pkbis_pkg;

  localparam int NUM_SLOTS = 64;
  localparam int SET_CAP   = 16;

  localparam int SLOT_W  = 6;
  localparam int ID_W    = 16;
  localparam int CNT_W   = $clog2(SET_CAP + 1);
  localparam int RAM_AW  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef struct packed {
    opcode_t             opcode;
    logic [SLOT_W-1:0]   slot_index;
    logic [ID_W-1:0]     ident;
    logic                learn_ok;
    logic                external_has;
  } req_t;

  typedef struct packed {
    logic hit;
    logic added;
    logic dropped_full;
  } rsp_t;

  // one memory row holds a whole set and its fill count
  typedef struct packed {
    logic [CNT_W-1:0]               count;
    logic [SET_CAP-1:0][ID_W-1:0]   ents;
  } row_t;

  localparam int ROW_W = $bits(row_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LOOKUP,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic latch_req;
    logic ram_rd;
    logic evaluate;
    logic finish;
  } ctrl_cmd_t;

endpackage

FILE: rtl/core/pkbis_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkbis_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pkbis_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/pkbis_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkbis_ctrl
// Sequencer: accept, row read, lookup, finish and report.
// ----------------------------------------------------------------------------
module pkbis_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  output logic                  done,
  output pkbis_pkg::ctrl_cmd_t  cmd
);

  import pkbis_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    cmd           = '0;
    busy          = 1'b1;
    done          = 1'b0;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.latch_req = 1'b1;
          state_next    = ST_READ;
        end
      end
      ST_READ: begin
        cmd.ram_rd = 1'b1;
        state_next = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        cmd.evaluate = 1'b1;
        state_next   = ST_FINISH;
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        done       = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/pkbis_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkbis_datapath
// Request register, set memory, row valid bits, match logic and result.
// ----------------------------------------------------------------------------
module pkbis_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  pkbis_pkg::ctrl_cmd_t  cmd,
  input  pkbis_pkg::req_t       req,
  input  logic                  cfg_wr_en,
  input  logic                  cfg_wr_data,
  output pkbis_pkg::rsp_t       rsp
);

  import pkbis_pkg::*;

  req_t              req_q;
  logic              ext_en;
  logic [NUM_SLOTS-1:0] row_valid;
  logic [RAM_AW-1:0] slot_addr;
  logic [ROW_W-1:0]  rd_data;
  row_t              rd_row;
  row_t              new_row;
  row_t              wr_row;
  logic              add_q;
  rsp_t              rsp_next;

  logic [CNT_W-1:0]  count;
  logic              present;
  logic              slot_ok;
  logic              id_nz;
  logic              ext_yes;
  logic              want_add;

  assign slot_addr = RAM_AW'(req_q.slot_index);
  assign rd_row    = row_t'(rd_data);

  always_ff @(posedge clk) begin
    if (cmd.latch_req) begin
      req_q <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ext_en <= 1'b0;
    end else if (cfg_wr_en) begin
      ext_en <= cfg_wr_data;
    end
  end

  pkbis_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_SLOTS)
  ) u_set_ram (
    .clk   (clk),
    .we    (cmd.finish & add_q),
    .waddr (slot_addr),
    .wdata (ROW_W'(wr_row)),
    .re    (cmd.ram_rd),
    .raddr (slot_addr),
    .rdata (rd_data)
  );

  // a row never written since the last clear counts as empty
  always_comb begin
    slot_ok  = ({1'b0, req_q.slot_index} < (SLOT_W + 1)'(NUM_SLOTS));
    id_nz    = (req_q.ident != '0);
    ext_yes  = ext_en & req_q.external_has;
    count    = row_valid[slot_addr] ? rd_row.count : '0;
    present  = 1'b0;
    for (int k = 0; k < SET_CAP; k++) begin
      if ((CNT_W'(k) < count) && (rd_row.ents[k] == req_q.ident)) begin
        present = 1'b1;
      end
    end
    want_add = (((req_q.opcode == OP_INSERT) && req_q.learn_ok) ||
                ((req_q.opcode == OP_QUERY) && ext_yes)) &&
               id_nz && slot_ok && !present;

    rsp_next.added        = want_add && (count < CNT_W'(SET_CAP));
    rsp_next.dropped_full = want_add && (count >= CNT_W'(SET_CAP));
    rsp_next.hit          = (req_q.opcode == OP_QUERY) && id_nz &&
                            (ext_yes || (slot_ok && present));

    new_row       = rd_row;
    new_row.count = count + CNT_W'(1);
    for (int k = 0; k < SET_CAP; k++) begin
      if (CNT_W'(k) == count) begin
        new_row.ents[k] = req_q.ident;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.evaluate) begin
      rsp    <= rsp_next;
      add_q  <= rsp_next.added;
      wr_row <= new_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (cmd.finish) begin
      if (req_q.opcode == OP_CLEAR) begin
        row_valid <= '0;
      end else if (add_q) begin
        row_valid[slot_addr] <= 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/per_key_bounded_id_set_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_key_bounded_id_set_core
// Per-slot sets of nonzero identifiers: clear, insert and query requests.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  request   start / busy         req (opcode, slot_index, ident, ...)
//  result    done (1-cycle)       rsp (hit, added, dropped_full)
//  config    cfg_wr_en            cfg_wr_data (external_enabled)
//
//  every request passes through accept, row read from the set memory,
//  lookup over the sixteen entries, then write back and result
//  busy is high from the cycle after accept until the result cycle ends
//  reset clears the row valid bits at once, so there is no clearing pass;
//  a clear request does the same in its finish cycle
//  the result is shown for one cycle only; the receiver cannot stall it
module per_key_bounded_id_set_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  pkbis_pkg::req_t   req,
  output logic              done,
  output pkbis_pkg::rsp_t   rsp,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data
);

  import pkbis_pkg::*;

  ctrl_cmd_t cmd;

  pkbis_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  pkbis_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .req         (req),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .rsp         (rsp)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy)
    else $error("not idle after result");

  a_add_xor_drop: assert property (@(posedge clk) disable iff (rst)
    done |-> !(rsp.added && rsp.dropped_full))
    else $error("added and dropped together");

  a_done_spacing: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

endmodule

FILE: tb/id_set_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// id_set_checker
// Watches the request, result and config channels of the identifier set
// core, keeps its own copy of every slot's set and compares each result.
// ----------------------------------------------------------------------------
module id_set_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             busy,
  input  pkbis_pkg::req_t  req,
  input  logic             done,
  input  pkbis_pkg::rsp_t  rsp,
  input  logic             cfg_wr_en,
  input  logic             cfg_wr_data,
  output int               fail_count,
  output int               pending,
  output int               checked,
  output int               hits,
  output int               drops
);

  import pkbis_pkg::*;

  logic [ID_W-1:0] id_table [NUM_SLOTS][SET_CAP];
  int unsigned     fill [NUM_SLOTS];
  logic            ext_en;
  rsp_t            rsp_due [$];

  function automatic void wipe_sets();
    foreach (fill[s]) fill[s] = 0;
    foreach (id_table[s, k]) id_table[s][k] = '0;
  endfunction

  function automatic bit holds(int unsigned slot, logic [ID_W-1:0] id);
    for (int unsigned k = 0; k < fill[slot]; k++)
      if (id_table[slot][k] == id) return 1'b1;
    return 1'b0;
  endfunction

  // store id unless present; a full set rejects it
  function automatic void learn(int unsigned slot, logic [ID_W-1:0] id, inout rsp_t r);
    if (id == '0 || holds(slot, id)) return;
    if (fill[slot] >= SET_CAP) begin
      r.dropped_full = 1'b1;
      return;
    end
    id_table[slot][fill[slot]] = id;
    fill[slot]++;
    r.added = 1'b1;
  endfunction

  function automatic rsp_t outcome(req_t r);
    rsp_t        o;
    int unsigned slot;
    bit          slot_ok;
    o       = '0;
    slot    = r.slot_index;
    slot_ok = slot < NUM_SLOTS;
    case (r.opcode)
      OP_CLEAR: begin
        wipe_sets();
      end
      OP_INSERT: begin
        if (r.learn_ok && r.ident != '0 && slot_ok) learn(slot, r.ident, o);
      end
      OP_QUERY: begin
        if (r.ident != '0) begin
          if (ext_en && r.external_has) begin
            if (slot_ok) learn(slot, r.ident, o);
            o.hit = 1'b1;
          end else if (slot_ok) begin
            o.hit = holds(slot, r.ident);
          end
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      wipe_sets();
      ext_en = 1'b0;
      rsp_due.delete();
      fail_count = 0;
      checked = 0;
      hits = 0;
      drops = 0;
    end else begin
      if (cfg_wr_en) ext_en = cfg_wr_data;
      if (done) begin
        if (rsp_due.size() == 0) begin
          $error("result with no request outstanding");
          fail_count++;
        end else begin
          want = rsp_due.pop_front();
          checked++;
          if (want.hit) hits++;
          if (want.dropped_full) drops++;
          if (rsp.hit !== want.hit) begin
            $error("hit: expected %0b, got %0b", want.hit, rsp.hit);
            fail_count++;
          end
          if (rsp.added !== want.added) begin
            $error("added: expected %0b, got %0b", want.added, rsp.added);
            fail_count++;
          end
          if (rsp.dropped_full !== want.dropped_full) begin
            $error("dropped_full: expected %0b, got %0b", want.dropped_full,
                   rsp.dropped_full);
            fail_count++;
          end
        end
      end
      if (start && !busy) rsp_due.push_back(outcome(req));
    end
    pending = rsp_due.size();
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives clear, insert and query requests into the identifier set core,
// with directed corner cases first and then random traffic over a few slots
// under both settings of the external answer; a checker beside the core
// predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
  import pkbis_pkg::*;

  localparam int RAND_PHASES  = 8;
  localparam int PHASE_ITEMS  = 200;
  localparam int STALL_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = 20;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic cfg_wr_data = 1'b0;
  req_t req = '0;
  logic busy;
  logic done;
  rsp_t rsp;

  int fails;
  int pending;
  int checked;
  int hits;
  int drops;
  int sent = 0;

  always #10 clk = ~clk;

  per_key_bounded_id_set_core dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req         (req),
    .done        (done),
    .rsp         (rsp),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  id_set_checker chk (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req         (req),
    .done        (done),
    .rsp         (rsp),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fail_count  (fails),
    .pending     (pending),
    .checked     (checked),
    .hits        (hits),
    .drops       (drops)
  );

  function automatic req_t make_req(opcode_t op, logic [SLOT_W-1:0] slot,
                                    logic [ID_W-1:0] id, logic learn, logic ext);
    req_t r;
    r.opcode       = op;
    r.slot_index   = slot;
    r.ident        = id;
    r.learn_ok     = learn;
    r.external_has = ext;
    return r;
  endfunction

  // mostly a few slots and a small id pool so sets fill up and overflow
  function automatic req_t random_req(int span, logic [ID_W-1:0] pool_base);
    req_t r;
    int   pick;
    r    = '0;
    pick = $urandom_range(0, 999);
    if (pick < 5)        r.opcode = OP_CLEAR;
    else if (pick < 35)  r.opcode = OP_NONE;
    else if (pick < 520) r.opcode = OP_INSERT;
    else                 r.opcode = OP_QUERY;
    if ($urandom_range(1, 100) <= 85) r.slot_index = SLOT_W'($urandom_range(0, span - 1));
    else                              r.slot_index = SLOT_W'($urandom_range(0, 63));
    pick = $urandom_range(1, 100);
    if (pick <= 8)       r.ident = '0;
    else if (pick <= 20) r.ident = ID_W'($urandom_range(0, 65535));
    else                 r.ident = pool_base ^ ID_W'($urandom_range(0, 23));
    r.learn_ok     = $urandom_range(1, 100) <= 88;
    r.external_has = 1'($urandom_range(0, 1));
    return r;
  endfunction

  // returns at the edge where the request is taken
  task automatic send(req_t r);
    start <= 1'b1;
    req   <= r;
    sent++;
    do @(posedge clk); while (busy);
  endtask

  task automatic pause(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // hold off until every outstanding result has come back
  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic set_external(logic v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : watchdog
    int stall;
    stall = 0;
    while (stall < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (start && !busy) || done) stall = 0;
      else stall++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    int              span;
    int              idle_pct;
    logic [ID_W-1:0] pool_base;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // external answer off after reset
    send(make_req(OP_QUERY,  6'd0,  16'd1,     1'b1, 1'b1));
    send(make_req(OP_INSERT, 6'd0,  16'd0,     1'b1, 1'b0));
    send(make_req(OP_INSERT, 6'd5,  16'hFFFF,  1'b0, 1'b1));
    send(make_req(OP_INSERT, 6'd63, 16'hFFFF,  1'b1, 1'b0));
    send(make_req(OP_INSERT, 6'd63, 16'hFFFF,  1'b1, 1'b1));
    send(make_req(OP_QUERY,  6'd63, 16'hFFFF,  1'b0, 1'b0));
    send(make_req(OP_QUERY,  6'd63, 16'd0,     1'b1, 1'b1));
    send(make_req(OP_NONE,   6'd63, 16'hFFFF,  1'b1, 1'b1));
    send(make_req(OP_QUERY,  6'd5,  16'hFFFF,  1'b1, 1'b1));
    // fill slot 1 and go one past capacity
    for (int k = 1; k <= SET_CAP + 1; k++)
      send(make_req(OP_INSERT, 6'd1, ID_W'(16'h8000 | k), 1'b1, 1'b0));

    drain();
    set_external(1'b1);
    send(make_req(OP_QUERY, 6'd2,  16'h5A5A, 1'b0, 1'b1));
    send(make_req(OP_QUERY, 6'd2,  16'h5A5A, 1'b1, 1'b0));
    send(make_req(OP_QUERY, 6'd2,  16'h1234, 1'b1, 1'b0));
    send(make_req(OP_QUERY, 6'd1,  16'h7777, 1'b0, 1'b1));
    send(make_req(OP_QUERY, 6'd0,  16'd0,    1'b1, 1'b1));
    send(make_req(OP_CLEAR, 6'd0,  16'd0,    1'b0, 1'b0));
    send(make_req(OP_QUERY, 6'd63, 16'hFFFF, 1'b1, 1'b0));

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain();
      set_external(ph % 2 == 1);
      span      = $urandom_range(1, 4);
      pool_base = ID_W'($urandom);
      if (ph >= RAND_PHASES - 2 || ph % 3 == 1) idle_pct = 0;
      else                                     idle_pct = $urandom_range(10, 50);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send(random_req(span, pool_base));
        if (idle_pct != 0 && $urandom_range(0, 199) == 0) drain();
        else if ($urandom_range(1, 100) <= idle_pct) pause($urandom_range(1, 6));
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("summary: %0d requests, %0d results checked, %0d hits, %0d full-set drops",
             sent, checked, hits, drops);
    $display("covered: external answer on and off, zero and duplicate ids, full sets, clears");
    if (fails == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
